// ===== sv/mag_pkg.sv =====
// Package for the multi-ant grid block: item kinds, sequencer states, cell codes.
// No dependencies.
`default_nettype none
package mag_pkg;
    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_RUN   = 2'd1,
        K_READ  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_RD, S_SCAN, S_PRD, S_PLD, S_PWAIT, S_PLACE, S_OUT
    } t_state;

    localparam logic [3:0] C_WHITE = 4'd0;
    localparam logic [3:0] C_BLACK = 4'd1;
    localparam logic [3:0] C_AW    = 4'd2;
    localparam logic [3:0] C_AW_HI = 4'd5;
    localparam logic [3:0] C_AB    = 4'd6;
    localparam logic [3:0] C_AB_HI = 4'd9;
endpackage
`default_nettype wire

// ===== sv/multi_ant_grid_generation_top.sv =====
// Top level of the multi-ant grid block: cell store, ant queue and sequencer.
// Depends on mag_pkg.
`default_nettype none
// Usage: one input word per item (write, read or run generations) on a
// valid/ready channel; exactly one output word per item, held in an output
// register until taken. The block works on one item at a time and drops
// o_ready while busy.
// Sequence: a write goes straight to the output state, which writes the cell
// (if in range) and registers the word; a read first passes the read state
// while the store is read. A run gives its word after its last generation:
// each generation scans every cell through the single store port, then each
// queued ant is fetched from the queue and its cell read and written.
// After reset the store is cleared by a pass over all GRID_W*GRID_H cells,
// during which no item is accepted; edge_mode writes are taken at any time out of reset.
// A stalled receiver holds the result word; the next item may still be
// accepted, but its word waits in the last state until the first is taken.
module multi_ant_grid_generation_top #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire [1:0]  i_kind,
    input  wire [5:0]  i_x_pos,
    input  wire [5:0]  i_y_pos,
    input  wire [3:0]  i_write_value,
    input  wire [15:0] i_generations,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [3:0] o_read_value,
    output logic       o_done_res,
    input  wire        i_cfg_we,
    input  wire        i_cfg_data
);
    localparam int XW = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int CELLS = GRID_W * GRID_H;
    localparam int AW = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int CW = $clog2(CELLS + 1);
    localparam logic [XW-1:0] XMAX = XW'(GRID_W - 1);
    localparam logic [YW-1:0] YMAX = YW'(GRID_H - 1);

    logic [3:0] r_mem [DEPTH];
    logic [XW+YW+1:0] r_q [DEPTH];

    mag_pkg::t_state r_st, n_st;
    logic r_edge;
    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_k, n_k;
    logic [15:0] r_gens, n_gens;
    logic [1:0] r_kind, n_kind;
    logic [3:0] r_wv, n_wv;
    logic [3:0] r_rd, n_rd;
    logic [3:0] r_dat;
    logic [XW+YW+1:0] r_qd;
    logic [3:0] r_res, n_res;
    logic r_ov, n_ov;

    // Memory port requests.
    logic m_we;
    logic [AW-1:0] m_addr;
    logic [3:0] m_wd;
    logic q_we;
    logic [AW-1:0] q_wa, q_ra;
    logic [XW+YW+1:0] q_wd;

    logic in_x, in_y;
    logic [1:0] hd;
    logic is_w, is_b;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic off;
    logic [AW-1:0] cur_addr;
    logic [XW-1:0] px;
    logic [YW-1:0] py;
    logic [1:0] pd;

    assign in_x = ({26'd0, i_x_pos} < 32'(GRID_W));
    assign in_y = ({26'd0, i_y_pos} < 32'(GRID_H));
    assign cur_addr = {r_y, r_x};
    assign is_w = (r_dat >= mag_pkg::C_AW) && (r_dat <= mag_pkg::C_AW_HI);
    assign is_b = (r_dat >= mag_pkg::C_AB) && (r_dat <= mag_pkg::C_AB_HI);
    assign {py, px, pd} = r_qd;

    always_comb begin
        hd = is_w ? 2'(r_dat - mag_pkg::C_AW + 4'd1) : 2'(r_dat - mag_pkg::C_AB + 4'd3);
        nx = r_x;
        ny = r_y;
        off = 1'b0;
        case (hd)
            2'd0: begin
                off = (r_y == YMAX);
                ny = off ? '0 : r_y + 1'b1;
            end
            2'd1: begin
                off = (r_x == XMAX);
                nx = off ? '0 : r_x + 1'b1;
            end
            2'd2: begin
                off = (r_y == '0);
                ny = off ? YMAX : r_y - 1'b1;
            end
            default: begin
                off = (r_x == '0);
                nx = off ? XMAX : r_x - 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= mag_pkg::S_CLEAR;
            r_x <= '0;
            r_y <= '0;
            r_cnt <= '0;
            r_k <= '0;
            r_gens <= '0;
            r_ov <= 1'b0;
            r_edge <= 1'b0;
        end else begin
            r_st <= n_st;
            r_x <= n_x;
            r_y <= n_y;
            r_cnt <= n_cnt;
            r_k <= n_k;
            r_gens <= n_gens;
            r_ov <= n_ov;
            if (i_cfg_we) begin
                r_edge <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_wv <= n_wv;
        r_rd <= n_rd;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_addr] <= m_wd;
        end
        r_dat <= r_mem[m_addr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q[q_wa] <= q_wd;
        end
        r_qd <= r_q[q_ra];
    end

    always_comb begin
        n_st = r_st;
        n_x = r_x;
        n_y = r_y;
        n_cnt = r_cnt;
        n_k = r_k;
        n_gens = r_gens;
        n_kind = r_kind;
        n_wv = r_wv;
        n_rd = r_rd;
        n_res = r_res;
        n_ov = r_ov;
        o_ready = 1'b0;
        m_we = 1'b0;
        m_addr = cur_addr;
        m_wd = r_wv;
        q_we = 1'b0;
        q_wa = AW'(r_cnt);
        q_wd = {ny, nx, hd};
        q_ra = AW'(r_k);
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        case (r_st)
            mag_pkg::S_CLEAR: begin
                m_we = 1'b1;
                m_wd = mag_pkg::C_WHITE;
                n_x = r_x + 1'b1;
                if (r_x == XMAX) begin
                    n_x = '0;
                    n_y = r_y + 1'b1;
                    if (r_y == YMAX) begin
                        n_y = '0;
                        n_st = mag_pkg::S_IDLE;
                    end
                end
            end
            mag_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind = i_kind;
                    n_wv = i_write_value;
                    n_gens = i_generations;
                    n_x = XW'(i_x_pos);
                    n_y = YW'(i_y_pos);
                    n_rd = {3'd0, in_x && in_y};
                    case (mag_pkg::t_kind'(i_kind))
                        mag_pkg::K_WRITE: n_st = mag_pkg::S_OUT;
                        mag_pkg::K_READ:  n_st = mag_pkg::S_RD;
                        mag_pkg::K_RUN:   n_st = mag_pkg::S_OUT;
                        default:          n_st = mag_pkg::S_OUT;
                    endcase
                    if (mag_pkg::t_kind'(i_kind) == mag_pkg::K_RUN && i_generations != 16'd0) begin
                        n_x = '0;
                        n_y = '0;
                        n_cnt = '0;
                        n_st = mag_pkg::S_RD;
                    end
                end
            end
            mag_pkg::S_RD: begin
                // Address already on the port; the data lands next cycle.
                n_st = (mag_pkg::t_kind'(r_kind) == mag_pkg::K_RUN) ? mag_pkg::S_SCAN
                                                                     : mag_pkg::S_OUT;
            end
            mag_pkg::S_SCAN: begin
                if (is_w || is_b) begin
                    m_we = 1'b1;
                    m_wd = is_w ? mag_pkg::C_BLACK : mag_pkg::C_WHITE;
                    if (!(off && r_edge) && r_cnt < CW'(CELLS)) begin
                        q_we = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                n_x = r_x + 1'b1;
                n_st = mag_pkg::S_RD;
                if (r_x == XMAX) begin
                    n_x = '0;
                    n_y = r_y + 1'b1;
                    if (r_y == YMAX) begin
                        n_y = '0;
                        n_k = '0;
                        n_st = mag_pkg::S_PRD;
                    end
                end
            end
            mag_pkg::S_PRD: begin
                if (r_k >= r_cnt) begin
                    n_gens = r_gens - 1'b1;
                    n_cnt = '0;
                    n_st = (r_gens == 16'd1) ? mag_pkg::S_OUT : mag_pkg::S_RD;
                end else begin
                    n_st = mag_pkg::S_PLD;
                end
            end
            mag_pkg::S_PLD: begin
                n_x = px;
                n_y = py;
                m_addr = {py, px};
                n_st = mag_pkg::S_PWAIT;
            end
            mag_pkg::S_PWAIT: begin
                n_st = mag_pkg::S_PLACE;
            end
            mag_pkg::S_PLACE: begin
                if (r_dat <= mag_pkg::C_BLACK) begin
                    m_we = 1'b1;
                    m_wd = 4'({r_dat[0], 2'b00} + 4'd2 + {2'd0, pd});
                end else if (r_dat <= mag_pkg::C_AW_HI) begin
                    m_we = 1'b1;
                    m_wd = mag_pkg::C_BLACK;
                end else if (r_dat <= mag_pkg::C_AB_HI) begin
                    m_we = 1'b1;
                    m_wd = mag_pkg::C_WHITE;
                end
                n_k = r_k + 1'b1;
                q_ra = AW'(n_k);
                n_st = mag_pkg::S_PRD;
                if (n_k >= r_cnt) begin
                    n_x = '0;
                    n_y = '0;
                end
            end
            mag_pkg::S_OUT: begin
                // Wait here while the previous word is still held at the output.
                if (!r_ov || i_ready) begin
                    if (mag_pkg::t_kind'(r_kind) == mag_pkg::K_WRITE && r_rd[0]) begin
                        m_we = 1'b1;
                    end
                    n_res = (mag_pkg::t_kind'(r_kind) == mag_pkg::K_READ && r_rd[0]) ? r_dat
                                                                                      : '0;
                    n_ov = 1'b1;
                    n_x = '0;
                    n_y = '0;
                    n_st = mag_pkg::S_IDLE;
                end
            end
            default: n_st = mag_pkg::S_IDLE;
        endcase
    end

    assign o_valid = r_ov;
    assign o_read_value = r_res;
    assign o_done_res = 1'b1;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != mag_pkg::S_IDLE) |-> !o_ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_read_value)))
        else $error("result word lost under stall");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CELLS))
        else $error("ant queue overflow");
endmodule
`default_nettype wire

// ===== test/mag_checker.sv =====
// Checker for the multi-ant grid block: watches both channels, predicts each
// result word from its own grid model and compares. Depends on mag_pkg.
`timescale 1ns / 1ps
module mag_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire        o_ready,
    input  wire [1:0]  i_kind,
    input  wire [5:0]  i_x_pos,
    input  wire [5:0]  i_y_pos,
    input  wire [3:0]  i_write_value,
    input  wire [15:0] i_generations,
    input  wire        o_valid,
    input  wire        i_ready,
    input  wire [3:0]  o_read_value,
    input  wire        o_done_res,
    input  wire        i_cfg_we,
    input  wire        i_cfg_data,
    output int         fail_count,
    output int         pending
);
    localparam int W = 64;
    localparam int H = 64;
    localparam int N = W * H;

    logic [3:0]  grid [N];
    logic [11:0] ant_pos [N];
    logic [1:0]  ant_dir [N];
    int          n_ants;
    logic        wrap_off;
    // Expected words in order, as a small ring with write and read pointers.
    logic [3:0]  exp_read [256];
    logic [7:0]  exp_wr;
    logic [7:0]  exp_rd;
    logic [7:0]  exp_diff;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Queue an ant leaving (x,y) with heading hd: 0 N, 1 E, 2 S, 3 W.
    task automatic push_ant(input int x, input int y, input logic [1:0] hd);
        int nx, ny;
        bit off;
        nx = x;
        ny = y;
        off = 0;
        case (hd)
            2'd0: if (y == H - 1) begin off = 1; ny = 0; end else ny = y + 1;
            2'd1: if (x == W - 1) begin off = 1; nx = 0; end else nx = x + 1;
            2'd2: if (y == 0) begin off = 1; ny = H - 1; end else ny = y - 1;
            default: if (x == 0) begin off = 1; nx = W - 1; end else nx = x - 1;
        endcase
        if (!(off && wrap_off) && n_ants < N) begin
            ant_pos[n_ants] = 12'(ny * W + nx);
            ant_dir[n_ants] = hd;
            n_ants++;
        end
    endtask

    task automatic step_generation();
        logic [3:0] c;
        int p;
        n_ants = 0;
        for (int y = 0; y < H; y++) begin
            for (int x = 0; x < W; x++) begin
                c = grid[y * W + x];
                if (c >= mag_pkg::C_AW && c <= mag_pkg::C_AW_HI) begin
                    grid[y * W + x] = mag_pkg::C_BLACK;
                    push_ant(x, y, 2'(c - mag_pkg::C_AW + 1));
                end else if (c >= mag_pkg::C_AB && c <= mag_pkg::C_AB_HI) begin
                    grid[y * W + x] = mag_pkg::C_WHITE;
                    push_ant(x, y, 2'(c - mag_pkg::C_AB + 3));
                end
            end
        end
        for (int k = 0; k < n_ants; k++) begin
            p = ant_pos[k];
            c = grid[p];
            if (c <= mag_pkg::C_BLACK) grid[p] = 4'(c * 4 + mag_pkg::C_AW + ant_dir[k]);
            else if (c <= mag_pkg::C_AW_HI) grid[p] = mag_pkg::C_BLACK;
            else if (c <= mag_pkg::C_AB_HI) grid[p] = mag_pkg::C_WHITE;
        end
    endtask

    assign exp_diff = exp_wr - exp_rd;
    assign pending = int'(exp_diff);

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) grid[i] = mag_pkg::C_WHITE;
            wrap_off = 0;
            fail_count = 0;
            exp_wr = '0;
            exp_rd = '0;
        end else begin
            if (o_valid && i_ready) begin
                if (exp_wr == exp_rd) begin
                    report("unexpected word", o_read_value, 0);
                end else begin
                    if (o_read_value !== exp_read[exp_rd])
                        report("read_value", o_read_value, exp_read[exp_rd]);
                    if (o_done_res !== 1'b1) report("done_res", o_done_res, 1);
                    exp_rd = exp_rd + 8'd1;
                end
            end
            if (i_valid && o_ready) begin
                case (mag_pkg::t_kind'(i_kind))
                    mag_pkg::K_WRITE: grid[{i_y_pos, i_x_pos}] = i_write_value;
                    mag_pkg::K_RUN: for (int g = 0; g < i_generations; g++) step_generation();
                    default: ;
                endcase
                exp_read[exp_wr] = (mag_pkg::t_kind'(i_kind) == mag_pkg::K_READ)
                                   ? grid[{i_y_pos, i_x_pos}] : 4'd0;
                exp_wr = exp_wr + 8'd1;
            end
            if (i_cfg_we) wrap_off = i_cfg_data;
        end
    end
endmodule

// ===== test/testbench.sv =====
// Top of the multi-ant grid testbench: clock, reset, stimulus and verdict.
// Depends on mag_pkg, mag_checker and multi_ant_grid_generation_top.
`timescale 1ns / 1ps
module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_kind = mag_pkg::K_WRITE;
    logic [5:0]  i_x_pos = 0;
    logic [5:0]  i_y_pos = 0;
    logic [3:0]  i_write_value = 0;
    logic [15:0] i_generations = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [3:0]  o_read_value;
    logic        o_done_res;
    logic        i_cfg_we = 0;
    logic        i_cfg_data = 0;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    bit          calm = 0;

    localparam int QUIET_LIMIT = 3_000_000;

    always #2 i_clk = ~i_clk;

    multi_ant_grid_generation_top dut (.*);

    mag_checker checker_inst (.*);

    // Receiver stalls in about 30 percent of cycles, except during the calm stretch.
    always @(negedge i_clk) i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("FAIL multi_ant_grid_generation_top");
            $finish;
        end
    end

    task automatic send(input mag_pkg::t_kind k, input int x, input int y, input int v,
                        input int g);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 30) @(negedge i_clk);
        i_valid <= 1;
        i_kind <= k;
        i_x_pos <= 6'(x);
        i_y_pos <= 6'(y);
        i_write_value <= 4'(v);
        i_generations <= 16'(g);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    task automatic set_edge(input bit m);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send(mag_pkg::K_WRITE, $urandom_range(63), $urandom_range(63),
                 $urandom_range(99) < 90 ? $urandom_range(9) : $urandom_range(15), 0);
        else if (r < 80)
            send(mag_pkg::K_READ, $urandom_range(63), $urandom_range(63),
                 $urandom_range(15), 0);
        else if (r < 95)
            send(mag_pkg::K_RUN, 0, 0, 0,
                 $urandom_range(99) < 90 ? $urandom_range(3) : $urandom_range(16));
        else
            send(mag_pkg::K_NONE, $urandom_range(63), $urandom_range(63), 15,
                 $urandom_range(65535));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // Directed: corners, every heading on both colours, collisions, odd codes.
        send(mag_pkg::K_READ, 63, 63, 0, 0);
        send(mag_pkg::K_WRITE, 0, 0, 2, 0);
        send(mag_pkg::K_WRITE, 63, 63, 9, 0);
        send(mag_pkg::K_WRITE, 63, 0, 5, 0);
        send(mag_pkg::K_WRITE, 0, 63, 7, 0);
        send(mag_pkg::K_WRITE, 10, 10, 3, 0);
        send(mag_pkg::K_WRITE, 12, 10, 8, 0);
        send(mag_pkg::K_WRITE, 11, 11, 4, 0);
        send(mag_pkg::K_WRITE, 30, 30, 15, 0);
        send(mag_pkg::K_WRITE, 29, 30, 3, 0);
        send(mag_pkg::K_RUN, 0, 0, 0, 0);
        send(mag_pkg::K_RUN, 0, 0, 0, 1);
        send(mag_pkg::K_READ, 0, 0, 0, 0);
        send(mag_pkg::K_READ, 63, 63, 0, 0);
        send(mag_pkg::K_READ, 30, 30, 0, 0);
        send(mag_pkg::K_NONE, 63, 63, 15, 16'hFFFF);
        send(mag_pkg::K_RUN, 0, 0, 0, 3);
        send(mag_pkg::K_READ, 11, 10, 0, 0);
        set_edge(1);
        send(mag_pkg::K_WRITE, 0, 0, 6, 0);
        send(mag_pkg::K_WRITE, 63, 63, 2, 0);
        send(mag_pkg::K_RUN, 0, 0, 0, 2);
        send(mag_pkg::K_READ, 0, 0, 0, 0);
        send(mag_pkg::K_READ, 1, 0, 0, 0);
        for (int i = 0; i < 76; i++) begin
            calm = (i >= 30 && i < 50);
            if (i == 40) set_edge(0);
            if (i == 60) set_edge(1);
            random_item();
        end
        calm = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("PASS multi_ant_grid_generation_top");
        else $display("FAIL multi_ant_grid_generation_top");
        $finish;
    end
endmodule
